FILE: hw/rtl/stc_pkg.sv
// Shared types, constants and helper functions for the software TLB cache.
// Used by stc_ctrl, stc_dpath and software_tlb_cache_core; no dependencies.
`timescale 1ns / 1ps

package stc_pkg;

    localparam int TABLE_ENTRIES = 2048;
    localparam int ASID_COUNT    = 256;
    localparam int HASH_SHIFT    = 13;
    localparam int ODD_BIT       = 12;
    localparam int WORD_W        = 32;
    localparam int ASID_FIELD_W  = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ASID_W        = $clog2(ASID_COUNT);

    localparam logic [IDX_W-1:0]  IDX_MASK  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [WORD_W-1:0] ODD_MASK  = WORD_W'(1) << ODD_BIT;

    localparam logic CMD_PUT   = 1'b0;
    localparam logic CMD_PURGE = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [WORD_W-1:0]       entry_hi;
        logic [WORD_W-1:0]       pte_word;
        logic [ASID_FIELD_W-1:0] purge_asid;
    } in_t;

    typedef struct packed {
        logic [WORD_W-1:0] tag_out;
        logic [WORD_W-1:0] even_out;
        logic [WORD_W-1:0] odd_out;
        logic              asid_live;
    } out_t;

    typedef struct packed {
        logic [WORD_W-1:0] tag;
        logic [WORD_W-1:0] even;
        logic [WORD_W-1:0] odd;
    } entry_t;

    typedef struct packed {
        logic init_wr;
        logic cnt_inc;
        logic accept;
        logic put_commit;
        logic walk_rd;
        logic resp_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } ctl_sts_t;

    function automatic logic [IDX_W-1:0] hash_idx(input logic [WORD_W-1:0] tag);
        logic [WORD_W-1:0] h;
        h = tag ^ (tag >> HASH_SHIFT);
        return h[IDX_W-1:0] & IDX_MASK;
    endfunction

    function automatic logic asid_ok(input logic [ASID_FIELD_W-1:0] a);
        return {1'b0, a} < (ASID_FIELD_W + 1)'(ASID_COUNT);
    endfunction

endpackage

FILE: hw/rtl/software_tlb_cache_core.sv
// Put: the entry is read on the transfer; in S_PUT, once the result register is free, the
// merged entry is written back and the result register loaded. Purge: S_WALK reads every
// entry, S_LAST checks the final one, S_RESP loads the result register once it is free.
// Items never overlap. After reset a clearing pass zeroes the entry memory; s_ready stays
// low until it is done. The presence map and control registers clear at once.
`timescale 1ns / 1ps

module software_tlb_cache_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  stc_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output stc_pkg::out_t m_data
);

    stc_pkg::ctl_cmd_t cmd;
    stc_pkg::ctl_sts_t sts;

    stc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    stc_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

    // An accepted item keeps the input closed in the following cycle.
    a_accept_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input stayed open after a transfer");

    // A new result is only loaded when the previous one is gone or leaving.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put_commit || cmd.resp_load) |-> (!m_valid || m_ready))
        else $error("result register overwritten before transfer");

    // A nonzero tag is never reported with both page words empty.
    a_tag_has_page: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.tag_out == '0 || m_data.even_out != '0 || m_data.odd_out != '0))
        else $error("tag reported for an empty entry");

endmodule

FILE: hw/rtl/stc_ctrl.sv
// Controller state machine of the software TLB cache: clearing pass, put and purge walk.
// Depends on stc_pkg for the command and status structs.
`timescale 1ns / 1ps

module stc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_cmd,
    output logic              s_ready,
    input  stc_pkg::ctl_sts_t sts,
    output stc_pkg::ctl_cmd_t cmd
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            S_INIT: begin
                cmd.init_wr = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_cmd == stc_pkg::CMD_PURGE) ? S_WALK : S_PUT;
                end
            end
            S_PUT: begin
                if (sts.out_free) begin
                    cmd.put_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_WALK: begin
                cmd.walk_rd = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                // The final entry's read data is checked in this cycle.
                state_next = S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/stc_dpath.sv
// Datapath of the software TLB cache: entry memory, item register, presence map,
// walk counter and output register. Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  stc_pkg::in_t      s_data,
    input  logic              m_ready,
    output logic              m_valid,
    output stc_pkg::out_t     m_data,
    input  stc_pkg::ctl_cmd_t cmd,
    output stc_pkg::ctl_sts_t sts
);

    // Entry memory: tag, even and odd words side by side.
    stc_pkg::entry_t mem [stc_pkg::TABLE_ENTRIES];
    stc_pkg::entry_t rd_reg;

    logic [stc_pkg::IDX_W-1:0]        cnt_reg;
    logic [stc_pkg::IDX_W-1:0]        idx_reg;
    logic [stc_pkg::IDX_W-1:0]        chk_addr_reg;
    logic                             chk_vld_reg;
    logic [stc_pkg::WORD_W-1:0]       tag_reg;
    logic [stc_pkg::WORD_W-1:0]       pte_reg;
    logic                             odd_reg;
    logic [stc_pkg::ASID_FIELD_W-1:0] asid_reg;
    logic [stc_pkg::ASID_COUNT-1:0]   present_reg;
    logic                             out_valid_reg;
    stc_pkg::out_t                    out_data_reg;

    logic [stc_pkg::WORD_W-1:0]       in_tag;
    logic                             mem_re;
    logic [stc_pkg::IDX_W-1:0]        mem_raddr;
    logic                             mem_we;
    logic [stc_pkg::IDX_W-1:0]        mem_waddr;
    stc_pkg::entry_t                  mem_wdata;
    stc_pkg::entry_t                  put_entry;
    logic [stc_pkg::ASID_FIELD_W-1:0] chk_asid;
    logic                             chk_match;

    assign in_tag = s_data.entry_hi & ~stc_pkg::ODD_MASK;

    assign mem_re    = cmd.accept || cmd.walk_rd;
    assign mem_raddr = cmd.accept ? stc_pkg::hash_idx(in_tag) : cnt_reg;

    // Put read-modify-write: a tag mismatch takes the entry over with both halves zeroed.
    always_comb begin
        put_entry = rd_reg;
        if (rd_reg.tag != tag_reg) begin
            put_entry.tag  = tag_reg;
            put_entry.even = '0;
            put_entry.odd  = '0;
        end
        if (odd_reg) begin
            put_entry.odd = pte_reg;
        end else begin
            put_entry.even = pte_reg;
        end
        if (put_entry.even == '0 && put_entry.odd == '0) begin
            put_entry.tag = '0;
        end
    end

    assign chk_asid  = rd_reg.tag[stc_pkg::ASID_FIELD_W-1:0];
    assign chk_match = (chk_asid == asid_reg);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        priority if (cmd.init_wr) begin
            mem_we = 1'b1;
        end else if (cmd.put_commit) begin
            mem_we    = 1'b1;
            mem_waddr = idx_reg;
            mem_wdata = put_entry;
        end else if (chk_vld_reg && chk_match) begin
            // A purged entry loses its tag; the page words stay behind.
            mem_we         = 1'b1;
            mem_waddr      = chk_addr_reg;
            mem_wdata      = rd_reg;
            mem_wdata.tag  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            tag_reg  <= in_tag;
            pte_reg  <= s_data.pte_word;
            odd_reg  <= s_data.entry_hi[stc_pkg::ODD_BIT];
            idx_reg  <= stc_pkg::hash_idx(in_tag);
            asid_reg <= (s_data.cmd == stc_pkg::CMD_PURGE) ? s_data.purge_asid
                        : in_tag[stc_pkg::ASID_FIELD_W-1:0];
        end
        if (cmd.walk_rd) begin
            chk_addr_reg <= cnt_reg;
        end
        if (cmd.put_commit) begin
            out_data_reg.tag_out   <= put_entry.tag;
            out_data_reg.even_out  <= put_entry.even;
            out_data_reg.odd_out   <= put_entry.odd;
            out_data_reg.asid_live <= stc_pkg::asid_ok(asid_reg);
        end else if (cmd.resp_load) begin
            out_data_reg.tag_out   <= '0;
            out_data_reg.even_out  <= '0;
            out_data_reg.odd_out   <= '0;
            out_data_reg.asid_live <= stc_pkg::asid_ok(asid_reg)
                                      && present_reg[asid_reg[stc_pkg::ASID_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.cnt_inc) begin
                cnt_reg <= (cnt_reg == stc_pkg::IDX_LAST) ? '0 : cnt_reg + 1'b1;
            end
            chk_vld_reg <= cmd.walk_rd;

            // The presence map is rebuilt from scratch during a purge walk.
            priority if (cmd.accept && s_data.cmd == stc_pkg::CMD_PURGE) begin
                present_reg <= '0;
            end else if (cmd.put_commit && stc_pkg::asid_ok(asid_reg)) begin
                present_reg[asid_reg[stc_pkg::ASID_W-1:0]] <= 1'b1;
            end else if (chk_vld_reg && !chk_match && stc_pkg::asid_ok(chk_asid)) begin
                present_reg[chk_asid[stc_pkg::ASID_W-1:0]] <= 1'b1;
            end

            if (cmd.put_commit || cmd.resp_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.cnt_last = (cnt_reg == stc_pkg::IDX_LAST);
    assign sts.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: dv/stc_checker.sv
// Scoreboard for the software TLB cache: watches both channels, keeps its own TLB image
// and presence map, and compares every result transfer. Depends on stc_pkg only.
`timescale 1ns / 1ps

module stc_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  stc_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  stc_pkg::out_t m_data,
    output int            err_count,
    output int            result_count,
    output int            pending
);
    import stc_pkg::*;

    logic [WORD_W-1:0]     tag_img  [TABLE_ENTRIES];
    logic [WORD_W-1:0]     even_img [TABLE_ENTRIES];
    logic [WORD_W-1:0]     odd_img  [TABLE_ENTRIES];
    logic [ASID_COUNT-1:0] live_map;
    out_t                  lookup_q [$];
    int                    mismatches = 0;

    assign err_count = mismatches;

    function automatic void mark_live(input logic [ASID_FIELD_W-1:0] a);
        if (int'(a) < ASID_COUNT) live_map[a] = 1'b1;
    endfunction

    function automatic logic is_live(input logic [ASID_FIELD_W-1:0] a);
        if (int'(a) < ASID_COUNT) return live_map[a];
        return 1'b0;
    endfunction

    // Applies one command to the TLB image and returns the result it must produce.
    function automatic out_t tlb_update(input in_t it);
        logic [WORD_W-1:0]       tag;
        logic [ASID_FIELD_W-1:0] asid;
        int                      idx;
        int                      i;
        out_t                    r;
        r = '0;
        if (it.cmd == CMD_PUT) begin
            tag  = it.entry_hi & ~ODD_MASK;
            idx  = int'((tag ^ (tag >> HASH_SHIFT)) & WORD_W'(TABLE_ENTRIES - 1));
            asid = tag[ASID_FIELD_W-1:0];
            if (tag_img[idx] != tag) begin
                tag_img[idx]  = tag;
                even_img[idx] = '0;
                odd_img[idx]  = '0;
            end
            if (it.entry_hi[ODD_BIT]) begin
                odd_img[idx] = it.pte_word;
            end else begin
                even_img[idx] = it.pte_word;
            end
            if (even_img[idx] == '0 && odd_img[idx] == '0) tag_img[idx] = '0;
            mark_live(asid);
            r.tag_out   = tag_img[idx];
            r.even_out  = even_img[idx];
            r.odd_out   = odd_img[idx];
            r.asid_live = is_live(asid);
        end else begin
            // Empty entries carry tag 0, so they count toward ASID 0 in the rebuilt map.
            live_map = '0;
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                if (tag_img[i][ASID_FIELD_W-1:0] == it.purge_asid) begin
                    tag_img[i] = '0;
                end else begin
                    mark_live(tag_img[i][ASID_FIELD_W-1:0]);
                end
            end
            r.asid_live = is_live(it.purge_asid);
        end
        return r;
    endfunction

    task automatic report_bad(input string what, input out_t want, input out_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s: expected tag %h even %h odd %h live %b,",
                     $time, what, want.tag_out, want.even_out, want.odd_out, want.asid_live);
            $display("    got tag %h even %h odd %h live %b",
                     got.tag_out, got.even_out, got.odd_out, got.asid_live);
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        int   i;
        if (!aresetn) begin
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                tag_img[i]  = '0;
                even_img[i] = '0;
                odd_img[i]  = '0;
            end
            live_map = '0;
            lookup_q.delete();
            result_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (lookup_q.size() == 0) begin
                    report_bad("result transfer with nothing outstanding", '0, m_data);
                end else begin
                    want = lookup_q.pop_front();
                    if (m_data.tag_out !== want.tag_out) begin
                        report_bad("tag_out mismatch", want, m_data);
                    end else if (m_data.even_out !== want.even_out) begin
                        report_bad("even_out mismatch", want, m_data);
                    end else if (m_data.odd_out !== want.odd_out) begin
                        report_bad("odd_out mismatch", want, m_data);
                    end else if (m_data.asid_live !== want.asid_live) begin
                        report_bad("asid_live mismatch", want, m_data);
                    end
                end
            end
            if (s_valid && s_ready) lookup_q.push_back(tlb_update(s_data));
        end
        pending <= lookup_q.size();
    end

endmodule

FILE: dv/tb_software_tlb_cache_core.sv
// Top-level testbench for software_tlb_cache_core: drives puts and purges in bursts,
// stalls the result side, and reports the verdict. Depends on stc_pkg, stc_checker and the core.
`timescale 1ns / 1ps

module tb_software_tlb_cache_core;
    import stc_pkg::*;

    localparam int RAND_ITEMS = 1400;
    localparam int POOL_N     = 24;
    localparam int IDLE_LIMIT = 4 * (TABLE_ENTRIES + 64);

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int err_count;
    int result_count;
    int pending;
    int n_sent      = 0;
    int n_put       = 0;
    int n_purge     = 0;
    int idle_cycles = 0;
    int rx_cycle    = 0;
    int stall_pct   = 0;

    logic [WORD_W-1:0] hi_pool [POOL_N];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    software_tlb_cache_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    stc_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .err_count    (err_count),
        .result_count (result_count),
        .pending      (pending)
    );

    // The result side changes its stall rate whenever the low byte of rx_cycle is zero, from never to almost always.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[7:0] == 8'd0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 25;
                2: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_software_tlb_cache_core: errors");
            $finish;
        end
    end

    function automatic in_t mk_put(input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] pte);
        in_t r;
        r.cmd        = CMD_PUT;
        r.entry_hi   = hi;
        r.pte_word   = pte;
        r.purge_asid = ASID_FIELD_W'($urandom());
        return r;
    endfunction

    function automatic in_t mk_purge(input logic [ASID_FIELD_W-1:0] a);
        in_t r;
        r.cmd        = CMD_PURGE;
        r.entry_hi   = $urandom();
        r.pte_word   = $urandom();
        r.purge_asid = a;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] fresh_hi();
        logic [WORD_W-1:0] h;
        h = $urandom();
        h[ASID_FIELD_W-1:0] = ASID_FIELD_W'($urandom_range(1, 6));
        return h;
    endfunction

    // Holds valid until the transfer; returns just after the accepting edge.
    task automatic send_item(input in_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        if (it.cmd == CMD_PUT) begin
            n_put++;
        end else begin
            n_purge++;
        end
    endtask

    // Mostly puts on a small set of page pairs so entries fill both halves, collide
    // and get purged; the rest are random addresses.
    task automatic pick_item(output in_t it);
        logic [WORD_W-1:0] base;
        int                roll;
        base = hi_pool[$urandom_range(0, POOL_N - 1)];
        if ($urandom_range(0, 49) == 0) hi_pool[$urandom_range(0, POOL_N - 1)] = fresh_hi();
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            it = mk_purge(($urandom_range(0, 3) != 0) ? base[ASID_FIELD_W-1:0]
                                                       : ASID_FIELD_W'($urandom()));
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                it = mk_put(base, $urandom());
            end else if (roll < 78) begin
                // Bits 31..24 do not enter the index, so this lands on the same entry.
                it = mk_put(base ^ {8'($urandom()), 24'h0}, $urandom());
            end else begin
                it = mk_put($urandom(), $urandom());
            end
            it.entry_hi[ODD_BIT] = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) it.pte_word = '0;
        end
    endtask

    initial begin
        in_t it;
        int  k;
        int  burst;
        int  n_rand;

        for (k = 0; k < POOL_N; k++) hi_pool[k] = fresh_hi();

        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(mk_put(32'h0000_0000, 32'h0000_0000));
        send_item(mk_put(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(mk_put(32'hFFFF_EFFF, 32'h0000_0000));
        // Both halves zero again, so the tag is cleared.
        send_item(mk_put(32'hFFFF_FFFF, 32'h0000_0000));
        // This tag hashes to entry 0, the entry a tag of 0 also maps to.
        send_item(mk_put(32'h0000_A005, 32'h1234_5678));
        send_item(mk_put(32'h0000_B005, 32'h9ABC_DEF0));
        send_item(mk_put(32'h0000_0123, 32'h0000_0001));
        send_item(mk_put(32'hFF00_0123, 32'h0000_0002));
        send_item(mk_put(32'hFF00_1123, 32'h0000_0000));
        send_item(mk_purge(8'h05));
        // A put with tag 0 hits the purged entry and sees its old even word.
        send_item(mk_put(32'h0000_1000, 32'h55AA_55AA));
        send_item(mk_purge(8'h00));
        send_item(mk_purge(8'hFF));
        send_item(mk_put(32'h0000_00FF, 32'hFFFF_FFFF));
        // Empty entries keep ASID 0 alive after a purge of another id.
        send_item(mk_purge(8'h80));
        send_item(mk_put(32'h8000_0080, 32'h8000_0000));
        send_item(mk_put(32'h7FFF_EF7F, 32'h7FFF_FFFF));
        send_item(mk_purge(8'h23));

        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && n_rand < RAND_ITEMS; k++) begin
                pick_item(it);
                send_item(it);
                n_rand++;
            end
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        while (result_count < n_sent) @(posedge aclk);
        repeat (TABLE_ENTRIES + 8) @(posedge aclk);

        $display("Run covered %0d puts and %0d purges; %0d result transfers compared.",
                 n_put, n_purge, result_count);
        $display("Mismatches: %0d, results still outstanding: %0d.", err_count, pending);
        if (err_count == 0 && pending == 0) begin
            $display("tb_software_tlb_cache_core: clean");
        end else begin
            $display("tb_software_tlb_cache_core: errors");
        end
        $finish;
    end

endmodule

FILE: software_tlb_cache_core.f
hw/rtl/stc_pkg.sv
hw/rtl/stc_ctrl.sv
hw/rtl/stc_dpath.sv
hw/rtl/software_tlb_cache_core.sv
dv/stc_checker.sv
dv/tb_software_tlb_cache_core.sv
